FILE: design/base64_block_codec_macros.svh
// Assertion macros shared by the codec modules.
// Each macro expands to one labeled concurrent assertion that is disabled
// during reset. Defining NO_ASSERTIONS removes them all.
`ifndef BASE64_BLOCK_CODEC_MACROS_SVH
`define BASE64_BLOCK_CODEC_MACROS_SVH

`ifndef NO_ASSERTIONS
`define B64BC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("codec check failed");
`define B64BC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("codec check failed");
`else
`define B64BC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define B64BC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/b64bc_pkg.sv
`timescale 1ns / 1ps

package b64bc_pkg;

    // Four lanes, each handling one group of three bytes or four characters.
    localparam int LANES = 4;

    localparam int ADDR_W = 3;
    localparam logic REG_DIRECTION = 1'b0;

    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;

    localparam logic [5:0] SEXTET_LOWER = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT = 6'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } sextet_t;

    typedef struct packed {
        logic [31:0] enc;
        logic [23:0] dec;
        logic        bad;
    } lane_res_t;

    typedef struct packed {
        logic valid;
        logic enc;
    } stage_ctl_t;

    // Sextet to alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] ch;
        if (v < SEXTET_LOWER) begin
            ch = CHAR_UPPER_A + {2'b00, v};
        end else if (v < SEXTET_DIGIT) begin
            ch = CHAR_LOWER_A + {2'b00, v - SEXTET_LOWER};
        end else if (v < SEXTET_PLUS) begin
            ch = CHAR_DIGIT_0 + {2'b00, v - SEXTET_DIGIT};
        end else if (v == SEXTET_PLUS) begin
            ch = CHAR_PLUS;
        end else begin
            ch = CHAR_SLASH;
        end
        return ch;
    endfunction

    // Alphabet character to sextet; ok is low for anything outside the alphabet.
    function automatic sextet_t dec_char(input logic [7:0] ch);
        sextet_t s;
        s.ok  = 1'b1;
        s.val = '0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            s.val = 6'(ch - CHAR_UPPER_A);
        end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            s.val = 6'(ch - CHAR_LOWER_A) + SEXTET_LOWER;
        end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
            s.val = 6'(ch - CHAR_DIGIT_0) + SEXTET_DIGIT;
        end else if (ch == CHAR_PLUS) begin
            s.val = SEXTET_PLUS;
        end else if (ch == CHAR_SLASH) begin
            s.val = SEXTET_SLASH;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

FILE: design/b64bc_in_if.sv
`timescale 1ns / 1ps

interface b64bc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] word_lo;
    logic [63:0] word_hi;

    modport source (output valid, output word_lo, output word_hi, input ready);
    modport sink   (input valid, input word_lo, input word_hi, output ready);
endinterface

FILE: design/b64bc_out_if.sv
`timescale 1ns / 1ps

interface b64bc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_lo;
    logic [63:0] result_hi;
    logic        bad_char;

    modport source (output valid, output result_lo, output result_hi,
                    output bad_char, input ready);
    modport sink   (input valid, input result_lo, input result_hi,
                    input bad_char, output ready);
endinterface

FILE: design/b64bc_lane.sv
`timescale 1ns / 1ps

// One conversion lane: three bytes to four characters and four characters
// to three bytes, both computed and registered; the merge stage picks one.
module b64bc_lane (
    input  logic                  clk,
    input  logic                  load,
    input  logic [23:0]           bytes,
    input  logic [31:0]           chars,
    output b64bc_pkg::lane_res_t  res
);

    b64bc_pkg::lane_res_t res_reg;
    b64bc_pkg::lane_res_t res_next;

    logic [5:0]           x0, x1, x2, x3;
    b64bc_pkg::sextet_t   sa, sb, sc, sd;

    always_comb
    begin
        x0 = bytes[7:2];
        x1 = {bytes[1:0], bytes[15:12]};
        x2 = {bytes[11:8], bytes[23:22]};
        x3 = bytes[21:16];

        sa = b64bc_pkg::dec_char(chars[7:0]);
        sb = b64bc_pkg::dec_char(chars[15:8]);
        sc = b64bc_pkg::dec_char(chars[23:16]);
        sd = b64bc_pkg::dec_char(chars[31:24]);
        // Invalid characters count as zero sextets; the merge stage clears
        // the whole result anyway when any lane flags one.
        if (!sa.ok) sa.val = '0;
        if (!sb.ok) sb.val = '0;
        if (!sc.ok) sc.val = '0;
        if (!sd.ok) sd.val = '0;

        res_next.enc = {b64bc_pkg::enc_char(x3), b64bc_pkg::enc_char(x2),
                        b64bc_pkg::enc_char(x1), b64bc_pkg::enc_char(x0)};
        res_next.dec = {sc.val[1:0], sd.val,
                        sb.val[3:0], sc.val[5:2],
                        sa.val, sb.val[5:4]};
        res_next.bad = !(sa.ok && sb.ok && sc.ok && sd.ok);
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: design/b64bc_merge.sv
`timescale 1ns / 1ps
`include "base64_block_codec_macros.svh"

// Merge stage: packs the lane results into the outgoing block, folds the
// lane error flags together and holds the result in the output register.
module b64bc_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64bc_pkg::stage_ctl_t s1_ctl,
    input  b64bc_pkg::lane_res_t  lane_res [b64bc_pkg::LANES],
    output logic                  out_free,
    b64bc_out_if.source           results
);

    logic        valid_reg,  valid_next;
    logic        enc_reg;
    logic [63:0] lo_reg,     lo_next;
    logic [63:0] hi_reg,     hi_next;
    logic        bad_reg,    bad_next;
    logic        load;
    logic [95:0] dec_bytes;
    logic        any_bad;

    assign out_free = !valid_reg || results.ready;
    assign load     = s1_ctl.valid && out_free;

    always_comb
    begin
        dec_bytes = {lane_res[3].dec, lane_res[2].dec, lane_res[1].dec, lane_res[0].dec};
        any_bad   = lane_res[0].bad | lane_res[1].bad | lane_res[2].bad | lane_res[3].bad;
        if (s1_ctl.enc == b64bc_pkg::DIR_ENCODE) begin
            lo_next  = {lane_res[1].enc, lane_res[0].enc};
            hi_next  = {lane_res[3].enc, lane_res[2].enc};
            bad_next = 1'b0;
        end else if (any_bad) begin
            lo_next  = '0;
            hi_next  = '0;
            bad_next = 1'b1;
        end else begin
            lo_next  = dec_bytes[63:0];
            hi_next  = {32'd0, dec_bytes[95:64]};
            bad_next = 1'b0;
        end

        if (load) begin
            valid_next = 1'b1;
        end else if (results.ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            bad_reg <= bad_next;
            enc_reg <= s1_ctl.enc;
        end
    end

    assign results.valid     = valid_reg;
    assign results.result_lo = lo_reg;
    assign results.result_hi = hi_reg;
    assign results.bad_char  = bad_reg;

    `B64BC_ASSERT_IMPLY(a_bad_zeroes_data, clk, rst_n, valid_reg && bad_reg, lo_reg == 64'd0 && hi_reg == 64'd0)
    `B64BC_ASSERT_IMPLY(a_encode_never_bad, clk, rst_n, valid_reg && enc_reg, !bad_reg)
    `B64BC_ASSERT_IMPLY(a_decode_tail_zero, clk, rst_n, valid_reg && !enc_reg, hi_reg[63:32] == 32'd0)
    `B64BC_ASSERT_NEXT(a_stall_keeps_result, clk, rst_n, valid_reg && !results.ready, valid_reg)
    `B64BC_ASSERT_IMPLY(a_waiting_stage_blocks, clk, rst_n, s1_ctl.valid && !out_free, !load)

endmodule

FILE: design/base64_block_codec.sv
`timescale 1ns / 1ps
// An accepted block waits in the lane registers until the output register is free.
// Throughput: one block per cycle in either direction while the sink keeps up;
// four lanes each take one group of three bytes or four characters, and one
// merge stage follows them.
// Reset (rst_n, asynchronous, active low) empties both pipeline stages and sets
// the direction register to decode. There is no clearing pass after reset.

// Base64 block codec, standard alphabet.
//
// The block is a two-stage pipeline. In the first stage four identical lanes
// each convert one group: in encode mode three input bytes become four
// alphabet characters, in decode mode four characters become three bytes and
// a per-lane flag marks any character outside the alphabet. Both directions
// are computed in every lane and registered; the direction is carried next
// to them in the stage control.
//
// The merge stage packs the four lane results into the 128-bit result. For a
// decode request it ORs the lane error flags and, if any is set, zeroes the
// data and raises bad_char. The result sits in an output register, and the
// first stage refills as soon as the output register is free or being taken,
// so a request can enter every cycle while the sink keeps up.
//
// The direction register is written over the APB-style port. Only bits 2 and
// up of the address select the register, so any byte address inside the
// first word reaches it; other words read as zero and ignore writes.
module base64_block_codec (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [b64bc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    b64bc_in_if.sink                      blocks,
    b64bc_out_if.source                   results
);

    logic                   direction_reg, direction_next;
    b64bc_pkg::stage_ctl_t  s1_ctl_reg, s1_ctl_next;
    logic                   out_free;
    logic                   in_accept;
    logic                   reg_hit;
    logic [127:0]           word;
    b64bc_pkg::lane_res_t   lane_res [b64bc_pkg::LANES];

    // Configuration port: always ready, single direction register.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[b64bc_pkg::ADDR_W-1:2] == b64bc_pkg::REG_DIRECTION);
    assign prdata  = reg_hit ? {31'd0, direction_reg} : 32'd0;

    always_comb
    begin
        direction_next = direction_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            direction_next = pwdata[0];
        end
    end

    // The first stage takes a new request whenever it is empty or its
    // current contents move to the output register in the same cycle.
    assign blocks.ready = !s1_ctl_reg.valid || out_free;
    assign in_accept    = blocks.valid && blocks.ready;

    always_comb
    begin
        s1_ctl_next = s1_ctl_reg;
        if (in_accept) begin
            s1_ctl_next.valid = 1'b1;
            s1_ctl_next.enc   = direction_reg;
        end else if (out_free) begin
            s1_ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            direction_reg <= b64bc_pkg::DIR_DECODE;
            s1_ctl_reg    <= '0;
        end else begin
            direction_reg <= direction_next;
            s1_ctl_reg    <= s1_ctl_next;
        end
    end

    assign word = {blocks.word_hi, blocks.word_lo};

    // Lane g encodes bytes 3g..3g+2 or decodes characters 4g..4g+3.
    for (genvar g = 0; g < b64bc_pkg::LANES; g++) begin : g_lane
        b64bc_lane u_lane (
            .clk   (clk),
            .load  (in_accept),
            .bytes (word[24*g +: 24]),
            .chars (word[32*g +: 32]),
            .res   (lane_res[g])
        );
    end

    b64bc_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_ctl   (s1_ctl_reg),
        .lane_res (lane_res),
        .out_free (out_free),
        .results  (results)
    );

endmodule

FILE: test/base64_block_codec_checker.sv
`timescale 1ns / 1ps

module base64_block_codec_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [b64bc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready,
    b64bc_in_if                          blocks,
    b64bc_out_if                         results,
    output int                           fail_count,
    output int                           pending
);

    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        bad;
    } codec_word_t;

    logic        direction;
    codec_word_t converted_blocks[$];

    // Bit 6 is set when the character belongs to the alphabet.
    function automatic logic [6:0] sextet_of_char(input logic [7:0] ch);
        for (int i = 0; i < 64; i++)
        begin
            if (ALPHABET[i] == ch)
                return {1'b1, 6'(i)};
        end
        return 7'd0;
    endfunction

    function automatic codec_word_t convert_block(input logic dir, input logic [63:0] lo,
                                                  input logic [63:0] hi);
        logic [127:0] src;
        logic [127:0] dst;
        logic [7:0]   s0;
        logic [7:0]   s1;
        logic [7:0]   s2;
        logic [6:0]   sx [4];
        logic [23:0]  bits;
        logic         bad;
        codec_word_t  r;
        src = {hi, lo};
        dst = '0;
        bad = 1'b0;
        for (int g = 0; g < 4; g++)
        begin
            if (dir == b64bc_pkg::DIR_ENCODE)
            begin
                s0 = src[24*g +: 8];
                s1 = src[24*g+8 +: 8];
                s2 = src[24*g+16 +: 8];
                dst[32*g +: 8]    = ALPHABET[s0[7:2]];
                dst[32*g+8 +: 8]  = ALPHABET[{s0[1:0], s1[7:4]}];
                dst[32*g+16 +: 8] = ALPHABET[{s1[3:0], s2[7:6]}];
                dst[32*g+24 +: 8] = ALPHABET[s2[5:0]];
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    sx[i] = sextet_of_char(src[32*g+8*i +: 8]);
                    if (!sx[i][6])
                        bad = 1'b1;
                end
                bits = {sx[0][5:0], sx[1][5:0], sx[2][5:0], sx[3][5:0]};
                dst[24*g +: 24] = {bits[7:0], bits[15:8], bits[23:16]};
            end
        end
        if (bad)
            dst = '0;
        r.lo  = dst[63:0];
        r.hi  = dst[127:64];
        r.bad = bad;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        codec_word_t want;
        logic [31:0] reg_value;
        if (!rst_n)
        begin
            direction = b64bc_pkg::DIR_DECODE;
            converted_blocks.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            // Results leave before new requests are queued, so a result can
            // never be matched against a request taken at the same edge.
            if (results.valid && results.ready)
            begin
                if (converted_blocks.size() == 0)
                begin
                    $error("result with no request outstanding: lo %h hi %h bad_char %b",
                           results.result_lo, results.result_hi, results.bad_char);
                    fail_count++;
                end
                else
                begin
                    want = converted_blocks.pop_front();
                    if (results.result_lo !== want.lo)
                    begin
                        $error("result_lo: expected %h, actual %h", want.lo,
                               results.result_lo);
                        fail_count++;
                    end
                    if (results.result_hi !== want.hi)
                    begin
                        $error("result_hi: expected %h, actual %h", want.hi,
                               results.result_hi);
                        fail_count++;
                    end
                    if (results.bad_char !== want.bad)
                    begin
                        $error("bad_char: expected %b, actual %b", want.bad,
                               results.bad_char);
                        fail_count++;
                    end
                end
            end
            if (blocks.valid && blocks.ready)
                converted_blocks.push_back(convert_block(direction, blocks.word_lo,
                                                         blocks.word_hi));
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[b64bc_pkg::ADDR_W-1:2] == b64bc_pkg::REG_DIRECTION)
                        direction = pwdata[0];
                end
                else
                begin
                    reg_value = '0;
                    if (paddr[b64bc_pkg::ADDR_W-1:2] == b64bc_pkg::REG_DIRECTION)
                        reg_value[0] = direction;
                    if (prdata !== reg_value)
                    begin
                        $error("prdata: expected %h, actual %h", reg_value, prdata);
                        fail_count++;
                    end
                end
            end
            pending <= converted_blocks.size();
        end
    end

endmodule

FILE: test/tb_base64_block_codec.sv
`timescale 1ns / 1ps

// Top of the codec testbench. It only makes stimulus: clock, reset, register
// accesses on the APB-style port, requests on the block channel and ready on
// the result channel. The checker beside the block predicts every result and
// counts failures; this module reads that count to give the verdict.
module tb_base64_block_codec;

    // The slowest correct run is set by the longest sender gap, longest sink
    // stall and the pipeline for each request, so this limit leaves a wide
    // margin over roughly 700 requests.
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_REQUESTS  = 85;
    localparam int DRAIN_CYCLES    = 8;

    localparam logic [b64bc_pkg::ADDR_W-1:0] DIRECTION_ADDR =
        {b64bc_pkg::REG_DIRECTION, 2'b00};
    // The word after the direction register holds nothing: writes there are
    // dropped and reads return zero.
    localparam logic [b64bc_pkg::ADDR_W-1:0] SPARE_ADDR     =
        {~b64bc_pkg::REG_DIRECTION, 2'b00};

    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Bytes that sit right next to the alphabet ranges, plus the padding
    // character and the extremes of the byte range.
    localparam logic [7:0] NEAR_MISS [13] = '{8'h00, 8'h2a, 8'h2c, 8'h2e, 8'h3a, 8'h3d,
                                              8'h40, 8'h5b, 8'h60, 8'h7b, 8'h7f, 8'h80,
                                              8'hff};

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [b64bc_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    b64bc_in_if  blocks();
    b64bc_out_if results();

    int   fail_count;
    int   pending;
    int   cycles = 0;
    // Largest gap either side may draw in the current phase; zero gives a
    // stretch with no idling at all.
    int   max_gap = 3;
    logic mode;

    base64_block_codec i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .blocks  (blocks),
        .results (results)
    );

    base64_block_codec_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .blocks     (blocks),
        .results    (results),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Each side draws its wait per request; at least a quarter of the draws are zero
    // even in the idle-heavy phases so that back-to-back transfers still occur.
    function automatic int pick_gap();
        if (max_gap == 0 || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, max_gap);
    endfunction

    function automatic logic [127:0] text_block();
        logic [127:0] t;
        for (int k = 0; k < 16; k++)
            t[8*k +: 8] = ALPHABET[$urandom_range(0, 63)];
        return t;
    endfunction

    function automatic logic [127:0] with_char(input logic [127:0] t, input int pos,
                                               input logic [7:0] ch);
        t[8*pos +: 8] = ch;
        return t;
    endfunction

    // Offers one request and returns at the edge where it is taken. While the
    // channel idles, the payload carries junk that the block must not take.
    task automatic send_block(input logic [127:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            blocks.valid   <= 1'b0;
            blocks.word_lo <= {$urandom, $urandom};
            blocks.word_hi <= {$urandom, $urandom};
            repeat (gap) @(posedge clk);
        end
        blocks.valid   <= 1'b1;
        blocks.word_lo <= data[63:0];
        blocks.word_hi <= data[127:64];
        do @(posedge clk); while (!blocks.ready);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready, then it idles with
    // psel low so that back-to-back transfers each start on a fresh edge.
    task automatic apb_access(input logic is_write,
                              input logic [b64bc_pkg::ADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Drops valid and waits until every request has produced its result.
    // The count is sampled at the falling edge, away from the checker's update.
    task automatic wait_drained();
        blocks.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Only bit 0 of the written word matters; the upper bits carry junk so
    // that the block is seen to ignore them. The value is read back.
    task automatic set_direction(input logic dir);
        logic [31:0] data;
        data    = $urandom;
        data[0] = dir;
        wait_drained();
        apb_access(1'b1, DIRECTION_ADDR, data);
        apb_access(1'b0, DIRECTION_ADDR, '0);
        mode = dir;
    endtask

    // Decode traffic is mostly clean text so that the full byte assembly is
    // exercised; the rest has a few corrupted characters or is pure noise.
    task automatic send_random_text();
        logic [127:0] t;
        int           kind;
        int           hits;
        kind = $urandom_range(0, 19);
        if (kind < 14)
        begin
            t = text_block();
        end
        else if (kind < 18)
        begin
            t = text_block();
            hits = $urandom_range(1, 3);
            for (int h = 0; h < hits; h++)
            begin
                if ($urandom_range(0, 1) == 0)
                    t = with_char(t, $urandom_range(0, 15), NEAR_MISS[$urandom_range(0, 12)]);
                else
                    t = with_char(t, $urandom_range(0, 15), 8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            t = {$urandom, $urandom, $urandom, $urandom};
        end
        send_block(t);
    endtask

    // The sink side: per result it draws a stall, then holds ready high until
    // a result is taken.
    initial
    begin
        int stall;
        results.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                results.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results.ready <= 1'b1;
            do @(posedge clk); while (!results.valid);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        blocks.valid   = 1'b0;
        blocks.word_lo = '0;
        blocks.word_hi = '0;
        mode           = b64bc_pkg::DIR_DECODE;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The block comes out of reset in decode mode, so the directed decode
        // cases also check the reset value of the direction register.
        send_block({16{8'h41}});
        send_block({16{8'h2f}});
        // Every range boundary of the alphabet: A Z a z 0 9 + / twice.
        send_block({2{64'h2f2b39307a615a41}});
        send_block('0);
        send_block('1);
        send_block({16{8'h3d}});
        // A single character just outside the alphabet in otherwise clean text.
        for (int i = 0; i < 13; i++)
            send_block(with_char(text_block(), $urandom_range(0, 15), NEAR_MISS[i]));

        // A write to the empty word must leave the block decoding.
        wait_drained();
        apb_access(1'b1, SPARE_ADDR, '1);
        apb_access(1'b0, SPARE_ADDR, '0);
        apb_access(1'b0, DIRECTION_ADDR, '0);
        send_block(text_block());

        // Encode extremes; the upper four input bytes are never used.
        set_direction(b64bc_pkg::DIR_ENCODE);
        send_block('0);
        send_block('1);
        send_block({32'hffffffff, {4{24'h000000}}});
        send_block({{$urandom}, {4{24'hfc0fc0}}});
        send_block({{$urandom}, {4{24'h03f03f}}});

        // Random phases alternate the direction and change the idling level,
        // from none at all up to the longest gaps on both sides.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 3)
                0:       max_gap = 0;
                1:       max_gap = 4;
                default: max_gap = 18;
            endcase
            set_direction((phase % 2 == 0) ? b64bc_pkg::DIR_DECODE : b64bc_pkg::DIR_ENCODE);
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if (mode == b64bc_pkg::DIR_ENCODE)
                    send_block({$urandom, $urandom, $urandom, $urandom});
                else
                    send_random_text();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/b64bc_pkg.sv
design/b64bc_in_if.sv
design/b64bc_out_if.sv
design/b64bc_lane.sv
design/b64bc_merge.sv
design/base64_block_codec.sv
test/base64_block_codec_checker.sv
test/tb_base64_block_codec.sv
